/* rtl/bdc_pkg.sv */
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared types and constants for the de Casteljau subdivision block.
// ----------------------------------------------------------------------------
package bdc_pkg;

    // default sizing
    localparam int DEF_MAX_DEGREE = 15;
    localparam int DEF_COORD_BITS = 16;

    // fixed field widths
    localparam int DEGREE_BITS   = 4;
    localparam int T_BITS        = 17;
    localparam int FRAC_BITS     = 16;
    localparam int IDX_BITS      = 4;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 17;

    // t == 1.0 in Q1.16
    localparam logic [T_BITS-1:0] T_ONE = T_BITS'(65536);

    // reset values of the configuration registers
    localparam logic [DEGREE_BITS-1:0] DEGREE_RESET  = DEGREE_BITS'(3);
    localparam logic [T_BITS-1:0]      SPLIT_T_RESET = T_BITS'(32768);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_DEGREE  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPLIT_T = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEFT0,
        ST_FIRST,
        ST_ROUND,
        ST_GAP,
        ST_RIGHT
    } state_t;

    // what the datapath does with a word once it comes out of the store
    typedef enum logic [2:0] {
        RK_NONE,
        RK_LEFT0,
        RK_FIRST,
        RK_LERP,
        RK_RIGHT
    } rd_kind_t;

    // read command from controller to datapath
    typedef struct packed {
        rd_kind_t              kind;
        logic                  emit;
        logic [IDX_BITS-1:0]   idx;
        logic                  last;
    } rd_cmd_t;

endpackage

/* rtl/bdc_ctrl.sv */
// ----------------------------------------------------------------------------
// bdc_ctrl
// Sequencer: counts loaded points, walks the de Casteljau triangle one read
// per cycle within a round, then sweeps the store out as the right polygon.
// ----------------------------------------------------------------------------
module bdc_ctrl #(
    parameter int MAX_DEGREE = bdc_pkg::DEF_MAX_DEGREE
) (
    clk,
    rst_n,
    start,
    n,
    busy,
    ld_we,
    ld_addr,
    rd_addr,
    rd_cmd
);
    localparam int NPTS   = MAX_DEGREE + 1;
    localparam int ADDR_W = $clog2(NPTS);
    localparam int CNT_W  = $clog2(NPTS + 1);

    input  logic                 clk;
    input  logic                 rst_n;
    input  logic                 start;
    input  logic [ADDR_W-1:0]    n;
    output logic                 busy;
    output logic                 ld_we;
    output logic [ADDR_W-1:0]    ld_addr;
    output logic [ADDR_W-1:0]    rd_addr;
    output bdc_pkg::rd_cmd_t     rd_cmd;

    bdc_pkg::state_t     state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   k_reg, k_next;
    logic [ADDR_W-1:0]   r_reg, r_next;
    logic                load_done;
    logic                round_end;

    // last point of the curve arrives with this beat
    assign load_done = (count_reg >= CNT_W'(n));
    // last read of the current round
    assign round_end = (k_reg == ADDR_W'(n - r_reg + 1'b1));

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdc_pkg::ST_IDLE;
            count_reg <= '0;
            k_reg     <= '0;
            r_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            r_reg     <= r_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bdc_pkg::ST_IDLE:
            begin
                if (start && load_done)
                    state_next = bdc_pkg::ST_LEFT0;
            end
            bdc_pkg::ST_LEFT0:
            begin
                state_next = (n == '0) ? bdc_pkg::ST_RIGHT : bdc_pkg::ST_FIRST;
            end
            bdc_pkg::ST_FIRST:
            begin
                state_next = bdc_pkg::ST_ROUND;
            end
            bdc_pkg::ST_ROUND:
            begin
                if (round_end)
                    state_next = bdc_pkg::ST_GAP;
            end
            bdc_pkg::ST_GAP:
            begin
                state_next = (r_reg == n) ? bdc_pkg::ST_RIGHT : bdc_pkg::ST_FIRST;
            end
            bdc_pkg::ST_RIGHT:
            begin
                if (k_reg == n)
                    state_next = bdc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bdc_pkg::ST_IDLE;
            end
        endcase
    end

    // counter updates
    always_comb
    begin
        count_next = count_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        case (state_reg)
            bdc_pkg::ST_IDLE:
            begin
                if (start)
                    count_next = load_done ? '0 : CNT_W'(count_reg + 1'b1);
            end
            bdc_pkg::ST_LEFT0:
            begin
                k_next = '0;
                r_next = ADDR_W'(1);
            end
            bdc_pkg::ST_FIRST:
            begin
                k_next = ADDR_W'(1);
            end
            bdc_pkg::ST_ROUND:
            begin
                if (!round_end)
                    k_next = ADDR_W'(k_reg + 1'b1);
            end
            bdc_pkg::ST_GAP:
            begin
                k_next = '0;
                if (r_reg != n)
                    r_next = ADDR_W'(r_reg + 1'b1);
            end
            bdc_pkg::ST_RIGHT:
            begin
                k_next = ADDR_W'(k_reg + 1'b1);
            end
            default:
            begin
                k_next = '0;
            end
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        busy        = (state_reg != bdc_pkg::ST_IDLE);
        ld_we       = 1'b0;
        ld_addr     = count_reg[ADDR_W-1:0];
        rd_addr     = '0;
        rd_cmd.kind = bdc_pkg::RK_NONE;
        rd_cmd.emit = 1'b0;
        rd_cmd.idx  = '0;
        rd_cmd.last = 1'b0;
        case (state_reg)
            bdc_pkg::ST_IDLE:
            begin
                ld_we = start;
            end
            bdc_pkg::ST_LEFT0:
            begin
                rd_cmd.kind = bdc_pkg::RK_LEFT0;
                rd_cmd.emit = 1'b1;
            end
            bdc_pkg::ST_FIRST:
            begin
                rd_cmd.kind = bdc_pkg::RK_FIRST;
            end
            bdc_pkg::ST_ROUND:
            begin
                // first lerp of round r is left point r
                rd_addr     = k_reg;
                rd_cmd.kind = bdc_pkg::RK_LERP;
                rd_cmd.emit = (k_reg == ADDR_W'(1));
                rd_cmd.idx  = bdc_pkg::IDX_BITS'(r_reg);
            end
            bdc_pkg::ST_GAP:
            begin
                rd_cmd.kind = bdc_pkg::RK_NONE;
            end
            bdc_pkg::ST_RIGHT:
            begin
                // store now holds the right polygon in place
                rd_addr     = k_reg;
                rd_cmd.kind = bdc_pkg::RK_RIGHT;
                rd_cmd.emit = 1'b1;
                rd_cmd.idx  = bdc_pkg::IDX_BITS'(k_reg);
                rd_cmd.last = (k_reg == n);
            end
            default:
            begin
                rd_cmd.kind = bdc_pkg::RK_NONE;
            end
        endcase
    end

endmodule

/* rtl/bdc_datapath.sv */
// ----------------------------------------------------------------------------
// bdc_datapath
// Point store, one registered read per cycle, one lerp unit per coordinate
// and the registered result port.
// ----------------------------------------------------------------------------
module bdc_datapath #(
    parameter int MAX_DEGREE = bdc_pkg::DEF_MAX_DEGREE,
    parameter int COORD_BITS = bdc_pkg::DEF_COORD_BITS
) (
    clk,
    rst_n,
    ld_we,
    ld_addr,
    point_x,
    point_y,
    rd_addr,
    rd_cmd,
    t,
    out_valid,
    out_x,
    out_y,
    side,
    point_index,
    last
);
    localparam int NPTS   = MAX_DEGREE + 1;
    localparam int ADDR_W = $clog2(NPTS);
    localparam int CB     = COORD_BITS;
    localparam int PW     = CB + bdc_pkg::T_BITS + 2;
    localparam logic signed [PW-1:0] RND_C = PW'(1) << (bdc_pkg::FRAC_BITS - 1);

    input  logic                              clk;
    input  logic                              rst_n;
    input  logic                              ld_we;
    input  logic [ADDR_W-1:0]                 ld_addr;
    input  logic signed [CB-1:0]              point_x;
    input  logic signed [CB-1:0]              point_y;
    input  logic [ADDR_W-1:0]                 rd_addr;
    input  bdc_pkg::rd_cmd_t                  rd_cmd;
    input  logic [bdc_pkg::T_BITS-1:0]        t;
    output logic                              out_valid;
    output logic signed [CB-1:0]              out_x;
    output logic signed [CB-1:0]              out_y;
    output logic                              side;
    output logic [bdc_pkg::IDX_BITS-1:0]      point_index;
    output logic                              last;

    // (a*65536 + t*(b-a) + 32768) >> 16, floor shift
    function automatic logic signed [CB-1:0] lerp(
        input logic signed [CB-1:0]         a,
        input logic signed [CB-1:0]         b,
        input logic [bdc_pkg::T_BITS-1:0]   tv
    );
        logic signed [CB:0]                 diff;
        logic signed [bdc_pkg::T_BITS:0]    ts;
        logic signed [PW-1:0]               prod;
        logic signed [PW-1:0]               a_sh;
        logic signed [PW-1:0]               sum;
        diff = signed'({b[CB-1], b} - {a[CB-1], a});
        ts   = signed'({1'b0, tv});
        // full-width signed product of the difference and t
        prod = diff * ts;
        a_sh = PW'(a) <<< bdc_pkg::FRAC_BITS;
        sum  = a_sh + prod + RND_C;
        return sum[bdc_pkg::FRAC_BITS +: CB];
    endfunction

    logic [2*CB-1:0]         mem [NPTS];
    logic [2*CB-1:0]         rd_data_reg;
    bdc_pkg::rd_cmd_t        tag_reg;
    logic [ADDR_W-1:0]       tag_addr_reg;
    logic signed [CB-1:0]    a_x_reg, a_x_next;
    logic signed [CB-1:0]    a_y_reg, a_y_next;
    logic signed [CB-1:0]    b_x, b_y;
    logic signed [CB-1:0]    l_x, l_y;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [2*CB-1:0]         wr_data;
    logic                    out_valid_reg;
    logic signed [CB-1:0]    out_x_reg, out_y_reg;
    logic                    side_reg, last_reg;
    logic [bdc_pkg::IDX_BITS-1:0] idx_reg;

    assign b_x = rd_data_reg[2*CB-1:CB];
    assign b_y = rd_data_reg[CB-1:0];
    assign l_x = lerp(a_x_reg, b_x, t);
    assign l_y = lerp(a_y_reg, b_y, t);

    // store write port: input beat or lerp result back into place
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ld_addr;
        wr_data = {point_x, point_y};
        if (ld_we)
        begin
            wr_en = 1'b1;
        end
        else if (tag_reg.kind == bdc_pkg::RK_LERP)
        begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(tag_addr_reg - 1'b1);
            wr_data = {l_x, l_y};
        end
    end

    // point store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // left operand holds the previous word of the sweep
    always_comb
    begin
        a_x_next = a_x_reg;
        a_y_next = a_y_reg;
        if (tag_reg.kind == bdc_pkg::RK_FIRST || tag_reg.kind == bdc_pkg::RK_LERP)
        begin
            a_x_next = b_x;
            a_y_next = b_y;
        end
    end

    always_ff @(posedge clk)
    begin
        a_x_reg      <= a_x_next;
        a_y_reg      <= a_y_next;
        tag_addr_reg <= rd_addr;
    end

    // command tag is registered alongside the store read data, so the two line up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg.kind  <= bdc_pkg::RK_NONE;
            tag_reg.emit  <= 1'b0;
            tag_reg.idx   <= '0;
            tag_reg.last  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tag_reg       <= rd_cmd;
            out_valid_reg <= tag_reg.emit && (tag_reg.kind != bdc_pkg::RK_NONE);
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (tag_reg.emit)
        begin
            out_x_reg <= (tag_reg.kind == bdc_pkg::RK_LERP) ? l_x : b_x;
            out_y_reg <= (tag_reg.kind == bdc_pkg::RK_LERP) ? l_y : b_y;
            side_reg  <= (tag_reg.kind == bdc_pkg::RK_RIGHT);
            idx_reg   <= tag_reg.idx;
            last_reg  <= tag_reg.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign side        = side_reg;
    assign point_index = idx_reg;
    assign last        = last_reg;

endmodule

/* rtl/bezier_decasteljau_subdivide.sv */
// ----------------------------------------------------------------------------
// bezier_decasteljau_subdivide
// Splits a 2-D Bezier curve at t with the de Casteljau triangle.
// ----------------------------------------------------------------------------
// Usage:
//   Input: pulse start with point_x/point_y; a beat is taken when start is
//   high and busy is low. Points 0..degree are loaded, one per beat. The
//   beat that carries point n (n = degree, capped at MAX_DEGREE) starts the
//   split and raises busy.
//   Output: each result beat is on out_x/out_y/side/point_index/last for one
//   cycle with out_valid high. Left polygon 0..n comes first, then right
//   polygon 0..n; last marks right point n. There is no backpressure.
//   Datapath: one shared lerp unit per coordinate does one lerp per cycle
//   while a round of the triangle runs; the store has a single read port.
//   Each result goes from the registered store read, through the lerp where
//   one applies, into the registered result port.
//   Configuration: cfg_write with cfg_index/cfg_data; the user must see that
//   these are written only while idle, as the block does not enforce it.
//   Reset: degree 3, split_t 0.5, load count zero, no results pending.
// ----------------------------------------------------------------------------
module bezier_decasteljau_subdivide #(
    parameter int MAX_DEGREE = bdc_pkg::DEF_MAX_DEGREE,
    parameter int COORD_BITS = bdc_pkg::DEF_COORD_BITS
) (
    clk,
    rst_n,
    cfg_write,
    cfg_index,
    cfg_data,
    start,
    busy,
    point_x,
    point_y,
    out_valid,
    out_x,
    out_y,
    side,
    point_index,
    last
);
    localparam int NPTS   = MAX_DEGREE + 1;
    localparam int ADDR_W = $clog2(NPTS);

    input  logic                                   clk;
    input  logic                                   rst_n;
    input  logic                                   cfg_write;
    input  logic [bdc_pkg::CFG_IDX_BITS-1:0]       cfg_index;
    input  logic [bdc_pkg::CFG_DATA_BITS-1:0]      cfg_data;
    input  logic                                   start;
    output logic                                   busy;
    input  logic signed [COORD_BITS-1:0]           point_x;
    input  logic signed [COORD_BITS-1:0]           point_y;
    output logic                                   out_valid;
    output logic signed [COORD_BITS-1:0]           out_x;
    output logic signed [COORD_BITS-1:0]           out_y;
    output logic                                   side;
    output logic [bdc_pkg::IDX_BITS-1:0]           point_index;
    output logic                                   last;

    logic [bdc_pkg::DEGREE_BITS-1:0]  degree_reg;
    logic [bdc_pkg::T_BITS-1:0]       split_t_reg;
    logic [ADDR_W-1:0]                n_sat;
    logic [bdc_pkg::T_BITS-1:0]       t_sat;
    logic                             ld_we;
    logic [ADDR_W-1:0]                ld_addr;
    logic [ADDR_W-1:0]                rd_addr;
    bdc_pkg::rd_cmd_t                 rd_cmd;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg  <= bdc_pkg::DEGREE_RESET;
            split_t_reg <= bdc_pkg::SPLIT_T_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bdc_pkg::REG_DEGREE:
                    degree_reg <= cfg_data[bdc_pkg::DEGREE_BITS-1:0];
                bdc_pkg::REG_SPLIT_T:
                    split_t_reg <= cfg_data[bdc_pkg::T_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // saturate degree and t
    assign n_sat = (degree_reg > MAX_DEGREE) ? ADDR_W'(MAX_DEGREE) : ADDR_W'(degree_reg);
    assign t_sat = (split_t_reg > bdc_pkg::T_ONE) ? bdc_pkg::T_ONE : split_t_reg;

    bdc_ctrl #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .n       (n_sat),
        .busy    (busy),
        .ld_we   (ld_we),
        .ld_addr (ld_addr),
        .rd_addr (rd_addr),
        .rd_cmd  (rd_cmd)
    );

    bdc_datapath #(
        .MAX_DEGREE (MAX_DEGREE),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ld_we       (ld_we),
        .ld_addr     (ld_addr),
        .point_x     (point_x),
        .point_y     (point_y),
        .rd_addr     (rd_addr),
        .rd_cmd      (rd_cmd),
        .t           (t_sat),
        .out_valid   (out_valid),
        .out_x       (out_x),
        .out_y       (out_y),
        .side        (side),
        .point_index (point_index),
        .last        (last)
    );

endmodule
